@@ rtl/core/msplim_pkg.sv @@
// Shared constants and types of the motor stall power limiter.
package msplim_pkg;

    // Default averaging window, in samples.
    localparam int WINDOW_DEF = 8;

    // Payload widths.
    localparam int POWER_IN_W  = 16;
    localparam int VEL_W       = 16;
    localparam int POWER_OUT_W = 15;
    localparam int AVG_W       = 16;
    localparam int LIMIT_W     = 14;
    localparam int THRESH_W    = 16;
    localparam int CFG_DATA_W  = 16;

    // Absolute bound on the delivered power.
    localparam int POWER_MAX = 12000;

    // Register reset values.
    localparam logic [LIMIT_W-1:0]         LIMIT_RST  = LIMIT_W'(POWER_MAX);
    localparam logic signed [THRESH_W-1:0] THRESH_RST = '0;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LIMIT_FIRST   = 2'd0,
        CFG_LIMIT_SECOND  = 2'd1,
        CFG_THRESH_FIRST  = 2'd2,
        CFG_THRESH_SECOND = 2'd3
    } cfg_index_t;

endpackage

@@ rtl/core/msplim_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module msplim_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the read data until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/motor_stall_power_limiter_unit.sv @@
// Top level of the motor stall power limiter: sample window, averages, stall stages.
//
// Usage
//   Input channel (in_valid / in_stall) carries one sample per transaction:
//   commanded power, measured velocity and a protection enable. Output channel
//   (out_valid / out_stall) returns one result per sample, in order: limited
//   power, average speed, average power and a flag for a stall stage firing.
//   Configuration must be written through cfg_we / cfg_index / cfg_data only
//   while the block is idle (unenforced); writes take effect at the next edge.
//
//   A sample passes stage 1, stage 2 and the output register: accepting it
//   issues the window RAM read, the commit to stage 2 does the running-sum
//   update and write-back, and the move to the output register loads the
//   stall compare, clamps and the reciprocal multiply of the averages.
//   Throughput is one sample per cycle unless the receiver stalls, set by the
//   single RAM read-modify-write per sample; the two RAM ports sustain it.
//
//   Reset (rst_n low, asynchronous) empties the pipeline, clears the sums,
//   slot pointers and fill count and restores the register defaults. The RAM
//   is not cleared: slots not yet written since reset read as zero through
//   the fill count. When the receiver stalls, the result is held in the
//   output register; the stages behind it keep accepting until they fill,
//   and only then is in_stall raised.
module motor_stall_power_limiter_unit #(
    parameter int WINDOW = msplim_pkg::WINDOW_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,

    input  logic                                          in_valid,
    output logic                                          in_stall,
    input  logic signed [msplim_pkg::POWER_IN_W-1:0]      power_in,
    input  logic signed [msplim_pkg::VEL_W-1:0]           velocity,
    input  logic                                          protect_enable,

    output logic                                          out_valid,
    input  logic                                          out_stall,
    output logic signed [msplim_pkg::POWER_OUT_W-1:0]     power_out,
    output logic signed [msplim_pkg::AVG_W-1:0]           avg_speed,
    output logic signed [msplim_pkg::AVG_W-1:0]           avg_power,
    output logic                                          limit_applied,

    input  logic                                          cfg_we,
    input  msplim_pkg::cfg_index_t                        cfg_index,
    input  logic [msplim_pkg::CFG_DATA_W-1:0]             cfg_data
);

    import msplim_pkg::*;

    // Window addressing and fill count.
    localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam logic [ADDR_W-1:0] SLOT_LAST = ADDR_W'(WINDOW - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

    // Running sums hold up to WINDOW full-scale samples; compares get headroom
    // for negated, scaled thresholds.
    localparam int SUM_W = 16 + $clog2(WINDOW) + 1;
    localparam int CMP_W = SUM_W + 2;
    localparam logic signed [CMP_W-1:0] WIN_C = CMP_W'(WINDOW);

    // Divide by WINDOW as a multiply by a rounded-up reciprocal; the shift is
    // wide enough that the quotient is exact over the whole sum range.
    localparam int RCP_K = SUM_W + $clog2(WINDOW);
    localparam int RCP_W = RCP_K + 1;
    localparam longint unsigned RCP_L =
        ((64'd1 << RCP_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);
    localparam int PROD_W = SUM_W + RCP_W;

    // Clamp arithmetic width.
    localparam int CL_W = 18;
    localparam logic signed [CL_W-1:0] POWER_MAX_C = CL_W'(POWER_MAX);

    localparam int RAM_W = POWER_IN_W + VEL_W;

    typedef struct packed {
        logic out_move;
        logic commit;
        logic accept;
    } flow_t;

    function automatic logic stage_fires(
        input logic signed [CMP_W-1:0] ssum,
        input logic signed [CMP_W-1:0] psum,
        input logic signed [CMP_W-1:0] lim_w,
        input logic signed [CMP_W-1:0] thr_w
    );
        return ((ssum < thr_w) && (psum > lim_w)) ||
               ((ssum > -thr_w) && (psum < -lim_w));
    endfunction

    function automatic logic signed [CL_W-1:0] clamp_sym(
        input logic signed [CL_W-1:0] v,
        input logic signed [CL_W-1:0] lim
    );
        logic signed [CL_W-1:0] r;
        r = v;
        if (v > lim)
        begin
            r = lim;
        end
        else if (v < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0]         limit_first_reg;
    logic [LIMIT_W-1:0]         limit_second_reg;
    logic signed [THRESH_W-1:0] thresh_first_reg;
    logic signed [THRESH_W-1:0] thresh_second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_first_reg   <= LIMIT_RST;
            limit_second_reg  <= LIMIT_RST;
            thresh_first_reg  <= THRESH_RST;
            thresh_second_reg <= THRESH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIMIT_FIRST:   limit_first_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_LIMIT_SECOND:  limit_second_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_THRESH_FIRST:  thresh_first_reg  <= signed'(cfg_data[THRESH_W-1:0]);
                CFG_THRESH_SECOND: thresh_second_reg <= signed'(cfg_data[THRESH_W-1:0]);
                default:           limit_first_reg   <= limit_first_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow: a stage advances when the one ahead is empty or moving
    // ------------------------------------------------------------------
    logic  s1_valid_reg, s1_valid_next;
    logic  s2_valid_reg, s2_valid_next;
    logic  out_valid_reg, out_valid_next;
    flow_t flow;

    always_comb
    begin
        flow.out_move = !out_valid_reg || !out_stall;
        flow.commit   = s1_valid_reg && (!s2_valid_reg || flow.out_move);
        flow.accept   = in_valid && (!s1_valid_reg || flow.commit);
    end

    assign in_stall = s1_valid_reg && !flow.commit;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s2_valid_next  = s2_valid_reg;
        out_valid_next = out_valid_reg;
        if (flow.accept || flow.commit)
        begin
            s1_valid_next = flow.accept;
        end
        if (flow.commit || (s2_valid_reg && flow.out_move))
        begin
            s2_valid_next = flow.commit;
        end
        if (flow.out_move)
        begin
            out_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Window RAM: read the evicted sample on accept, write the new one on
    // commit. Read and write pointers advance separately.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] rd_slot_reg, rd_slot_next;
    logic [ADDR_W-1:0] wr_slot_reg, wr_slot_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [RAM_W-1:0]  ram_rdata;

    always_comb
    begin
        rd_slot_next = rd_slot_reg;
        wr_slot_next = wr_slot_reg;
        fill_next    = fill_reg;
        if (flow.accept)
        begin
            rd_slot_next = (rd_slot_reg == SLOT_LAST) ? '0 : rd_slot_reg + 1'b1;
        end
        if (flow.commit)
        begin
            wr_slot_next = (wr_slot_reg == SLOT_LAST) ? '0 : wr_slot_reg + 1'b1;
            if (fill_reg != FILL_FULL)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_slot_reg <= '0;
            wr_slot_reg <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            rd_slot_reg <= rd_slot_next;
            wr_slot_reg <= wr_slot_next;
            fill_reg    <= fill_next;
        end
    end

    // Stage 1 payload
    logic signed [POWER_IN_W-1:0] s1_power_reg;
    logic signed [VEL_W-1:0]      s1_vel_reg;
    logic                         s1_en_reg;
    logic                         s1_fwd_reg;
    logic [RAM_W-1:0]             s1_fwd_data_reg;

    // A read of the slot that is being written in the same cycle only happens
    // with a one-entry window; forward the new sample in that case.
    always_ff @(posedge clk)
    begin
        if (flow.accept)
        begin
            s1_power_reg    <= power_in;
            s1_vel_reg      <= velocity;
            s1_en_reg       <= protect_enable;
            s1_fwd_reg      <= flow.commit && (rd_slot_reg == wr_slot_reg);
            s1_fwd_data_reg <= {s1_power_reg, s1_vel_reg};
        end
    end

    msplim_ram #(
        .WIDTH  (RAM_W),
        .DEPTH  (WINDOW),
        .ADDR_W (ADDR_W)
    ) u_window_ram (
        .clk   (clk),
        .we    (flow.commit),
        .waddr (wr_slot_reg),
        .wdata ({s1_power_reg, s1_vel_reg}),
        .re    (flow.accept),
        .raddr (rd_slot_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1 -> 2: running-sum update. Slots not yet written read as zero.
    // ------------------------------------------------------------------
    logic [RAM_W-1:0]           old_word;
    logic signed [VEL_W-1:0]    old_vel;
    logic signed [POWER_IN_W-1:0] old_power;
    logic signed [SUM_W-1:0]    speed_sum_reg, speed_sum_next;
    logic signed [SUM_W-1:0]    power_sum_reg, power_sum_next;

    always_comb
    begin
        old_word = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
        if (fill_reg != FILL_FULL)
        begin
            old_word = '0;
        end
        old_power = signed'(old_word[RAM_W-1:VEL_W]);
        old_vel   = signed'(old_word[VEL_W-1:0]);
    end

    always_comb
    begin
        speed_sum_next = speed_sum_reg;
        power_sum_next = power_sum_reg;
        if (flow.commit)
        begin
            speed_sum_next = speed_sum_reg + SUM_W'(s1_vel_reg) - SUM_W'(old_vel);
            power_sum_next = power_sum_reg + SUM_W'(s1_power_reg) - SUM_W'(old_power);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_sum_reg <= '0;
            power_sum_reg <= '0;
        end
        else
        begin
            speed_sum_reg <= speed_sum_next;
            power_sum_reg <= power_sum_next;
        end
    end

    // Stage 2 payload; sums and fill count already reflect this sample and
    // hold while it waits here.
    logic signed [POWER_IN_W-1:0] s2_power_reg;
    logic                         s2_en_reg;

    always_ff @(posedge clk)
    begin
        if (flow.commit)
        begin
            s2_power_reg <= s1_power_reg;
            s2_en_reg    <= s1_en_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 -> output: stall stages, clamps and averages
    // ------------------------------------------------------------------
    logic signed [CMP_W-1:0] ssum_x, psum_x;
    logic signed [CMP_W-1:0] lim1_w, lim2_w, thr1_w, thr2_w;
    logic                    armed, fire1, fire2;
    logic signed [CL_W-1:0]  pw1, pw2, pw_final;

    always_comb
    begin
        ssum_x = CMP_W'(speed_sum_reg);
        psum_x = CMP_W'(power_sum_reg);
        lim1_w = signed'(CMP_W'(limit_first_reg)) * WIN_C;
        lim2_w = signed'(CMP_W'(limit_second_reg)) * WIN_C;
        thr1_w = CMP_W'(thresh_first_reg) * WIN_C;
        thr2_w = CMP_W'(thresh_second_reg) * WIN_C;

        armed = s2_en_reg && (fill_reg == FILL_FULL);
        fire1 = armed && stage_fires(ssum_x, psum_x, lim1_w, thr1_w);
        fire2 = armed && stage_fires(ssum_x, psum_x, lim2_w, thr2_w);

        pw1 = CL_W'(s2_power_reg);
        if (fire1)
        begin
            pw1 = clamp_sym(pw1, signed'(CL_W'(limit_first_reg)));
        end
        pw2 = pw1;
        if (fire2)
        begin
            pw2 = clamp_sym(pw1, signed'(CL_W'(limit_second_reg)));
        end
        pw_final = clamp_sym(pw2, POWER_MAX_C);
    end

    // Truncating division: divide the magnitude, then restore the sign.
    logic                speed_neg, power_neg;
    logic [SUM_W-1:0]    speed_mag, power_mag;
    logic [PROD_W-1:0]   speed_prod, power_prod;
    logic [SUM_W-1:0]    speed_q, power_q;
    logic signed [SUM_W-1:0] speed_avg, power_avg;

    always_comb
    begin
        speed_neg  = speed_sum_reg[SUM_W-1];
        power_neg  = power_sum_reg[SUM_W-1];
        speed_mag  = speed_neg ? unsigned'(-speed_sum_reg) : unsigned'(speed_sum_reg);
        power_mag  = power_neg ? unsigned'(-power_sum_reg) : unsigned'(power_sum_reg);
        speed_prod = PROD_W'(speed_mag) * PROD_W'(RCP);
        power_prod = PROD_W'(power_mag) * PROD_W'(RCP);
        speed_q    = speed_prod[RCP_K +: SUM_W];
        power_q    = power_prod[RCP_K +: SUM_W];
        speed_avg  = speed_neg ? -signed'(speed_q) : signed'(speed_q);
        power_avg  = power_neg ? -signed'(power_q) : signed'(power_q);
    end

    // Output register
    logic signed [POWER_OUT_W-1:0] power_out_reg;
    logic signed [AVG_W-1:0]       avg_speed_reg;
    logic signed [AVG_W-1:0]       avg_power_reg;
    logic                          limit_applied_reg;

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && flow.out_move)
        begin
            power_out_reg     <= pw_final[POWER_OUT_W-1:0];
            avg_speed_reg     <= speed_avg[AVG_W-1:0];
            avg_power_reg     <= power_avg[AVG_W-1:0];
            limit_applied_reg <= fire1 || fire2;
        end
    end

    assign out_valid     = out_valid_reg;
    assign power_out     = power_out_reg;
    assign avg_speed     = avg_speed_reg;
    assign avg_power     = avg_power_reg;
    assign limit_applied = limit_applied_reg;

endmodule
